@@ src/gtr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtr_pkg
// shared constants, font table and request codes for the 5x7 text renderer
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_BYTES   = 1024;
  localparam int ADDR_W        = 10;
  localparam int GLYPH_COLS    = 5;
  localparam int ADVANCE       = 6;
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;

  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef logic [39:0] glyph_t;

  // five columns packed, column 0 in the low byte
  function automatic glyph_t font_lookup(input logic [7:0] code);
    glyph_t g;
    logic [6:0] idx;
    if (code < FIRST_CODE || code > LAST_CODE) idx = 7'd0;
    else idx = 7'(code - FIRST_CODE);
    unique case (idx)
      7'd0:  g = 40'h0000000000; 7'd1:  g = 40'h00005F0000; 7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14; 7'd4:  g = 40'h122A7F2A24; 7'd5:  g = 40'h6264081323;
      7'd6:  g = 40'h5022554936; 7'd7:  g = 40'h0000030500; 7'd8:  g = 40'h0041221C00;
      7'd9:  g = 40'h001C224100; 7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0000305000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0000606000;
      7'd15: g = 40'h0204081020; 7'd16: g = 40'h3E4549513E; 7'd17: g = 40'h00407F4200;
      7'd18: g = 40'h4649516142; 7'd19: g = 40'h314B454121; 7'd20: g = 40'h107F121418;
      7'd21: g = 40'h3945454527; 7'd22: g = 40'h3049494A3C; 7'd23: g = 40'h0305097101;
      7'd24: g = 40'h3649494936; 7'd25: g = 40'h1E29494906; 7'd26: g = 40'h0000363600;
      7'd27: g = 40'h0000365600; 7'd28: g = 40'h0041221408; 7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0814224100; 7'd31: g = 40'h0609510102; 7'd32: g = 40'h3E41794932;
      7'd33: g = 40'h7E1111117E; 7'd34: g = 40'h364949497F; 7'd35: g = 40'h224141413E;
      7'd36: g = 40'h1C2241417F; 7'd37: g = 40'h414949497F; 7'd38: g = 40'h010909097F;
      7'd39: g = 40'h7A4949413E; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h013F414020; 7'd43: g = 40'h412214087F; 7'd44: g = 40'h404040407F;
      7'd45: g = 40'h7F020C027F; 7'd46: g = 40'h7F1008047F; 7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h060909097F; 7'd49: g = 40'h5E2151413E; 7'd50: g = 40'h462919097F;
      7'd51: g = 40'h3149494946; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h3F4038403F; 7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807; 7'd58: g = 40'h4345495161; 7'd59: g = 40'h0041417F00;
      7'd60: g = 40'h2010080402; 7'd61: g = 40'h007F414100; 7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040; 7'd64: g = 40'h0004020100; 7'd65: g = 40'h7854545420;
      7'd66: g = 40'h384444487F; 7'd67: g = 40'h2044444438; 7'd68: g = 40'h7F48444438;
      7'd69: g = 40'h1854545438; 7'd70: g = 40'h0201097E08; 7'd71: g = 40'h3E5252520C;
      7'd72: g = 40'h780404087F; 7'd73: g = 40'h00407D4400; 7'd74: g = 40'h003D444020;
      7'd75: g = 40'h004428107F; 7'd76: g = 40'h00407F4100; 7'd77: g = 40'h780418047C;
      7'd78: g = 40'h780404087C; 7'd79: g = 40'h3844444438; 7'd80: g = 40'h081414147C;
      7'd81: g = 40'h7C18141408; 7'd82: g = 40'h080404087C; 7'd83: g = 40'h2054545448;
      7'd84: g = 40'h2040443F04; 7'd85: g = 40'h7C2040403C; 7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C; 7'd88: g = 40'h4428102844; 7'd89: g = 40'h3C5050500C;
      7'd90: g = 40'h444C546444; 7'd91: g = 40'h0041360800; 7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0008364100; 7'd94: g = 40'h0810080810;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

  // one store access from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_mask;  // bits ORed in on write
    logic              clr;      // write zero instead of OR
  } mem_req_t;

endpackage
`default_nettype wire

@@ src/gtr_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtr_store
// frame store ram, one port, registered read, or-write or clear-write
// ----------------------------------------------------------------------------
module gtr_store (
  input  wire logic              clk,
  input  wire gtr_pkg::mem_req_t req,
  input  wire logic [7:0]        old_data,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [gtr_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.clr ? 8'd0 : (old_data | req.wr_mask);
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

@@ src/glyph_text_renderer_5x7_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_text_renderer_5x7_unit
// 5x7 bitmap text renderer into a page-organized frame store
// ----------------------------------------------------------------------------
// One item at a time. After reset the store is cleared by a pass over all
// 1024 bytes before the first item is taken; a clear request makes the same
// pass. A read goes through a wait state and an output state to its result beat. A character visits
// its glyph columns (5 at scale 1, 10 at scale 2) with one setup state each,
// then three pages per column, each page one state to check and one more for
// a read-modify-write when it gets pixels, plus a last state for the cursor;
// columns off screen are skipped.
module glyph_text_renderer_5x7_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_display_enabled_we,
  input  wire logic       cfg_display_enabled,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_new_string,
  input  wire logic [7:0] in_pos_x,
  input  wire logic [7:0] in_pos_y,
  input  wire logic       in_large_font,
  input  wire logic [9:0] in_read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_data
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_COL, ST_RD, ST_WR, ST_RDWAIT, ST_RDOUT
  } state_t;

  state_t            state_r;
  logic              en_r;
  logic [7:0]        cursor_r, line_r;
  logic              dbl_r;
  logic [9:0]        cnt_r;
  gtr_pkg::glyph_t   glyph_r;
  logic [2:0]        col_r;
  logic              sub_r;
  logic [7:0]        px_r;
  logic [15:0]       colbits_r;   // scaled column pixels, bit i at row line+i
  logic [1:0]        page_r;
  logic [9:0]        addr_r;
  logic [7:0]        mask_r;
  logic [7:0]        rd_data;
  gtr_pkg::mem_req_t mreq;

  // vertical geometry of one column at page page_r
  logic [7:0]  base_page;
  logic [2:0]  shift;
  logic [7:0]  pg;
  logic [23:0] spread;
  logic [7:0]  pmask;
  logic [7:0]  raw;
  logic [15:0] scaled;
  logic [7:0]  px_cand;
  logic [15:0] addr_full;

  assign in_ready = (state_r == ST_IDLE) && !out_valid;

  always_comb begin
    raw = glyph_r[8*col_r +: 8];
    for (int i = 0; i < 8; i++) begin
      scaled[2*i]   = raw[i];
      scaled[2*i+1] = raw[i];
    end
    if (!dbl_r) scaled = {8'd0, raw};
    px_cand = 8'(cursor_r + (dbl_r ? {4'd0, col_r, 1'b0} : {5'd0, col_r}) + {7'd0, sub_r});
    base_page = {3'd0, line_r[7:3]};
    shift     = line_r[2:0];
    pg        = 8'(base_page + {6'd0, page_r});
    spread    = {colbits_r, 8'd0} >> (4'd8 - {1'b0, shift});
    pmask     = spread[8*page_r +: 8];
    // rows wrap at 256, then rows below the screen are dropped
    for (int b = 0; b < 8; b++) begin
      if ({1'b0, pg[4:0], 3'(b)} >= 9'(gtr_pkg::SCREEN_HEIGHT)) pmask[b] = 1'b0;
    end
  end

  assign addr_full = 16'(px_r) + 16'(pg[4:0]) * 16'(gtr_pkg::SCREEN_WIDTH);

  always_comb begin
    mreq = '0;
    mreq.addr = addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        mreq.wr_en = 1'b1;
        mreq.clr   = 1'b1;
        mreq.addr  = cnt_r;
      end
      ST_RD: begin
        mreq.rd_en = 1'b1;
        mreq.addr  = addr_full[9:0];
      end
      ST_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_mask = mask_r;
      end
      ST_IDLE: begin
        mreq.rd_en = 1'b1;
        mreq.addr  = in_read_index;
      end
      default: ;
    endcase
  end

  gtr_store u_store (
    .clk      (clk),
    .req      (mreq),
    .old_data (rd_data),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      en_r      <= 1'b0;
      cursor_r  <= '0;
      line_r    <= '0;
      dbl_r     <= 1'b0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_display_enabled_we) en_r <= cfg_display_enabled;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + 10'd1;
          if (cnt_r == 10'(gtr_pkg::STORE_BYTES - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && in_ready && en_r) begin
            unique case (gtr_pkg::req_t'(in_req_type))
              gtr_pkg::REQ_DRAW: begin
                glyph_r <= gtr_pkg::font_lookup(in_char_code);
                if (in_new_string) begin
                  cursor_r <= in_pos_x;
                  line_r   <= in_pos_y;
                  dbl_r    <= in_large_font;
                end
                col_r   <= '0;
                sub_r   <= 1'b0;
                state_r <= ST_COL;
              end
              gtr_pkg::REQ_CLEAR: begin
                cnt_r   <= '0;
                state_r <= ST_CLEAR;
              end
              gtr_pkg::REQ_READ: state_r <= ST_RDWAIT;
              default: ;
            endcase
          end
        end
        ST_COL: begin
          if (col_r == 3'(gtr_pkg::GLYPH_COLS)) begin
            cursor_r <= 8'(cursor_r + (dbl_r ? 8'(2 * gtr_pkg::ADVANCE)
                                             : 8'(gtr_pkg::ADVANCE)));
            state_r  <= ST_IDLE;
          end else if ({1'b0, px_cand} >= 9'(gtr_pkg::SCREEN_WIDTH)) begin
            // rest of this glyph column is skipped
            col_r <= col_r + 3'd1;
            sub_r <= 1'b0;
          end else begin
            px_r      <= px_cand;
            colbits_r <= scaled;
            page_r    <= '0;
            state_r   <= ST_RD;
            if (dbl_r && !sub_r) sub_r <= 1'b1;
            else begin
              sub_r <= 1'b0;
              col_r <= col_r + 3'd1;
            end
          end
        end
        ST_RD: begin
          addr_r  <= addr_full[9:0];
          mask_r  <= pmask;
          if (pmask == 8'd0 || addr_full >= 16'(gtr_pkg::STORE_BYTES)) begin
            if (page_r == 2'd2) state_r <= ST_COL;
            else page_r <= page_r + 2'd1;
          end else begin
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          if (page_r == 2'd2) state_r <= ST_COL;
          else begin
            page_r  <= page_r + 2'd1;
            state_r <= ST_RD;
          end
        end
        ST_RDWAIT: state_r <= ST_RDOUT;
        ST_RDOUT: begin
          out_read_data <= rd_data;
          out_valid     <= 1'b1;
          state_r       <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the 5x7 text renderer against a behavioral copy of its frame store:
// draws, clears and byte reads go through the input channel with random
// gaps, and every returned byte is compared with the predicted store byte.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 2200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_display_enabled_we = 1'b0;
  logic       cfg_display_enabled = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = gtr_pkg::REQ_DRAW;
  logic [7:0] in_char_code = '0;
  logic       in_new_string = 1'b0;
  logic [7:0] in_pos_x = '0;
  logic [7:0] in_pos_y = '0;
  logic       in_large_font = 1'b0;
  logic [9:0] in_read_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;

  // predicted state
  logic [7:0] store_model [gtr_pkg::STORE_BYTES];
  logic [7:0] cur_col, cur_row;
  logic       cur_big, enabled;
  logic [7:0] read_bytes_due [$];

  int  errors = 0;
  int  reads_seen = 0;
  int  hold_cycles = 0;
  bit  rx_random = 1'b1;

  glyph_text_renderer_5x7_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
  endtask

  // font table kept locally, column 0 first
  logic [7:0] font_cols [95][5] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E},'{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h0C,8'h52,8'h52,8'h52,8'h3E},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00},'{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h10,8'h08,8'h08,8'h10,8'h08}};

  task automatic render_char(input logic [7:0] code);
    int scale, idx, px, py, addr;
    logic [7:0] col;
    scale = cur_big ? 2 : 1;
    idx = (code < gtr_pkg::FIRST_CODE || code > gtr_pkg::LAST_CODE) ? 0 : int'(code) - 32;
    for (int c = 0; c < gtr_pkg::GLYPH_COLS; c++) begin
      col = font_cols[idx][c];
      for (int s = 0; s < scale; s++) begin
        px = (int'(cur_col) + c * scale + s) & 255;
        if (px >= gtr_pkg::SCREEN_WIDTH) break;
        for (int r = 0; r < 8; r++) begin
          if (col[r]) begin
            for (int t = 0; t < scale; t++) begin
              py = (int'(cur_row) + r * scale + t) & 255;
              addr = px + (py / 8) * gtr_pkg::SCREEN_WIDTH;
              if (py < gtr_pkg::SCREEN_HEIGHT && addr < gtr_pkg::STORE_BYTES)
                store_model[addr][py % 8] = 1'b1;
            end
          end
        end
      end
    end
    cur_col = cur_col + 8'(gtr_pkg::ADVANCE * scale);
  endtask

  task automatic predict(input gtr_pkg::req_t rq, input logic [7:0] code, input logic ns,
                         input logic [7:0] x, input logic [7:0] y, input logic big,
                         input logic [9:0] idx);
    if (!enabled) return;
    case (rq)
      gtr_pkg::REQ_DRAW: begin
        if (ns) begin
          cur_col = x;
          cur_row = y;
          cur_big = big;
        end
        render_char(code);
      end
      gtr_pkg::REQ_CLEAR: foreach (store_model[i]) store_model[i] = '0;
      gtr_pkg::REQ_READ: read_bytes_due.push_back(store_model[idx]);
      default: ;
    endcase
  endtask

  // valid stays up into a following item sent with no gap
  task automatic send_item(input gtr_pkg::req_t rq, input logic [7:0] code, input logic ns,
                           input logic [7:0] x, input logic [7:0] y, input logic big,
                           input logic [9:0] idx, input int max_gap = 10);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_char_code <= code;
    in_new_string <= ns;
    in_pos_x <= x;
    in_pos_y <= y;
    in_large_font <= big;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(rq, code, ns, x, y, big, idx);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_enable(input logic v);
    wait_idle();
    cfg_display_enabled_we <= 1'b1;
    cfg_display_enabled <= v;
    @(posedge clk);
    cfg_display_enabled_we <= 1'b0;
    enabled = v;
  endtask

  // receiver: a long hold-off stalls it, else random stalls, or always ready when random mode is off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (rx_random) begin
      out_ready <= ($urandom_range(0, 10) < 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reads_seen++;
      if (read_bytes_due.size() == 0) begin
        report("unexpected read beat", out_read_data, 8'h00);
      end else begin
        logic [7:0] want;
        want = read_bytes_due.pop_front();
        if (out_read_data !== want) report("read_data", out_read_data, want);
      end
    end
  end

  task automatic rand_read();
    send_item(gtr_pkg::REQ_READ, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 10'($urandom));
  endtask

  task automatic test_disabled();
    // nothing may happen while the display is off
    send_item(gtr_pkg::REQ_DRAW, 8'h41, 1'b1, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_NONE, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 10'h3FF);
  endtask

  task automatic test_directed();
    send_item(gtr_pkg::REQ_DRAW, 8'h21, 1'b1, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'd126, 1'b0, 8'hFF, 8'hFF, 1'b1, 10'h3FF);
    send_item(gtr_pkg::REQ_DRAW, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'd255, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'h57, 1'b1, 8'd124, 8'd60, 1'b1, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'h4D, 1'b1, 8'd250, 8'd252, 1'b1, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'h23, 1'b1, 8'hFF, 8'd5, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'd127, 1'b1, 8'd40, 8'd31, 1'b1, 10'd0);
    send_item(gtr_pkg::REQ_DRAW, 8'd31, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0);
    for (int i = 0; i < 6; i++)
      send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'(i * 128 + i));
    send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'h3FF);
    send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'd124);
    send_item(gtr_pkg::REQ_NONE, 8'h41, 1'b1, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'd2);
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        // mostly strings on screen, sometimes anywhere
        send_item(gtr_pkg::REQ_DRAW, 8'($urandom), ($urandom_range(0, 5) == 0),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63)),
                  1'($urandom), 10'($urandom));
      end else if (k < 97) begin
        rand_read();
      end else if (k < 98) begin
        send_item(gtr_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom), 10'($urandom));
      end else begin
        send_item(gtr_pkg::REQ_NONE, 8'($urandom), 1'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom), 10'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    // receiver stalls while reads queue up; once drained, more reads meet an always-ready receiver
    hold_cycles = 300;
    for (int i = 0; i < 12; i++)
      send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'($urandom), 0);
    in_valid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    rx_random = 1'b0;
    for (int i = 0; i < 40; i++)
      send_item(gtr_pkg::REQ_READ, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 10'($urandom), 0);
    rx_random = 1'b1;
  endtask

  initial begin
    foreach (store_model[i]) store_model[i] = '0;
    cur_col = '0;
    cur_row = '0;
    cur_big = 1'b0;
    enabled = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled();
    set_enable(1'b1);
    test_directed();
    test_random(800);
    set_enable(1'b0);
    test_disabled();
    set_enable(1'b1);
    test_backpressure();
    test_random(800);
    wait_idle();
    $display("covered draws at both scales, clears, reads and ignored requests,");
    $display("%0d read beats checked with idle, stalled and disabled phases", reads_seen);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

endmodule
